>>> hw/rtl/keyed_accumulator_table_unit_macros.svh
// Assertion macros for the keyed accumulator table RTL.
`ifndef KEYED_ACCUMULATOR_TABLE_UNIT_MACROS_SVH
`define KEYED_ACCUMULATOR_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define KAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KAT_ASSERT(lbl, prop, msg)
`define KAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/kat_pkg.sv
// Package: sizes, entry and write types, and sequencer states of the accumulator table.
package kat_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = IDX_W + 1;
    localparam int KEY_W       = 16;
    localparam int DELTA_W     = 8;
    localparam int WIN_W       = 32;
    localparam int VIS_W       = 32;
    localparam int OUT_IDX_W   = 6;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [WIN_W-1:0] wins;
        logic [VIS_W-1:0]        visits;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/keyed_accumulator_table_unit.sv
// Top level: keyed accumulator table with sequential scan and saturating update.
//
//  channel | direction | ports                                            | beat
//  s_      | in        | s_valid s_ready s_key s_win_delta s_visit_delta  | one update
//  m_      | out       | m_valid m_ready m_hit m_table_full m_entry_index | one result
//          |           | m_wins_now m_visits_now                          |
//
// One beat at a time: accept, then scan the entries in order through the registered
// memory read port, then an update step (skipped when the table is full and the key
// is absent), then the result is held until taken.
// Reset empties the table at once via a fill count; no clearing pass.
// s_ready is low from accept until the result beat completes.
`include "keyed_accumulator_table_unit_macros.svh"
module keyed_accumulator_table_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kat_pkg::KEY_W-1:0]           s_key,
    input  logic signed [kat_pkg::DELTA_W-1:0]  s_win_delta,
    input  logic [kat_pkg::DELTA_W-1:0]         s_visit_delta,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic                                m_table_full,
    output logic [kat_pkg::OUT_IDX_W-1:0]       m_entry_index,
    output logic signed [kat_pkg::WIN_W-1:0]    m_wins_now,
    output logic [kat_pkg::VIS_W-1:0]           m_visits_now
);
    import kat_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic signed [WIN_W-1:0] WIN_MAX = {1'b0, {(WIN_W-1){1'b1}}};
    localparam logic signed [WIN_W-1:0] WIN_MIN = {1'b1, {(WIN_W-1){1'b0}}};

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [KEY_W-1:0]           key_reg, key_next;
    logic [DELTA_W-1:0]         wdelta_reg, wdelta_next;
    logic [DELTA_W-1:0]         vdelta_reg, vdelta_next;
    logic                       hit_reg, hit_next;
    logic                       out_hit_reg, out_hit_next;
    logic                       out_full_reg, out_full_next;
    logic [OUT_IDX_W-1:0]       out_idx_reg, out_idx_next;
    logic signed [WIN_W-1:0]    out_wins_reg, out_wins_next;
    logic [VIS_W-1:0]           out_visits_reg, out_visits_next;

    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    entry_t                     rd_data;
    wr_req_t                    wr;

    logic                       slot_valid;
    logic signed [WIN_W-1:0]    base_w;
    logic [VIS_W-1:0]           base_v;
    logic [WIN_W:0]             wsum;
    logic [VIS_W:0]             vsum;
    logic signed [WIN_W-1:0]    wins_sat;
    logic [VIS_W-1:0]           visits_sat;

    kat_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // saturating update of the selected entry; a claimed entry starts from zero
    always_comb begin
        base_w = hit_reg ? rd_data.wins : '0;
        base_v = hit_reg ? rd_data.visits : '0;
        wsum   = {base_w[WIN_W-1], base_w}
               + {{(WIN_W+1-DELTA_W){wdelta_reg[DELTA_W-1]}}, wdelta_reg};
        vsum   = {1'b0, base_v} + (VIS_W+1)'(vdelta_reg);
        if (wsum[WIN_W] != wsum[WIN_W-1]) begin
            wins_sat = wsum[WIN_W] ? WIN_MIN : WIN_MAX;
        end else begin
            wins_sat = wsum[WIN_W-1:0];
        end
        visits_sat = vsum[VIS_W] ? {VIS_W{1'b1}} : vsum[VIS_W-1:0];
    end

    assign slot_valid = {1'b0, idx_reg} < fill_reg;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        key_next        = key_reg;
        wdelta_next     = wdelta_reg;
        vdelta_next     = vdelta_reg;
        hit_next        = hit_reg;
        out_hit_next    = out_hit_reg;
        out_full_next   = out_full_reg;
        out_idx_next    = out_idx_reg;
        out_wins_next   = out_wins_reg;
        out_visits_next = out_visits_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr              = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next    = s_key;
                    wdelta_next = s_win_delta;
                    vdelta_next = s_visit_delta;
                    idx_next    = '0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!slot_valid) begin
                    hit_next   = 1'b0;
                    state_next = ST_UPD;
                end else if (rd_data.key == key_reg) begin
                    hit_next   = 1'b1;
                    state_next = ST_UPD;
                end else if (idx_reg == LAST_IDX) begin
                    out_hit_next    = 1'b0;
                    out_full_next   = 1'b1;
                    out_idx_next    = '0;
                    out_wins_next   = '0;
                    out_visits_next = '0;
                    state_next      = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            ST_UPD: begin
                wr.en           = 1'b1;
                wr.addr         = idx_reg;
                wr.data.key     = key_reg;
                wr.data.wins    = wins_sat;
                wr.data.visits  = visits_sat;
                if (!hit_reg) begin
                    fill_next = fill_reg + 1'b1;
                end
                out_hit_next    = hit_reg;
                out_full_next   = 1'b0;
                out_idx_next    = OUT_IDX_W'(idx_reg);
                out_wins_next   = wins_sat;
                out_visits_next = visits_sat;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        wdelta_reg     <= wdelta_next;
        vdelta_reg     <= vdelta_next;
        hit_reg        <= hit_next;
        out_hit_reg    <= out_hit_next;
        out_full_reg   <= out_full_next;
        out_idx_reg    <= out_idx_next;
        out_wins_reg   <= out_wins_next;
        out_visits_reg <= out_visits_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_DONE);
    assign m_hit         = out_hit_reg;
    assign m_table_full  = out_full_reg;
    assign m_entry_index = out_idx_reg;
    assign m_wins_now    = out_wins_reg;
    assign m_visits_now  = out_visits_reg;

    `KAT_ASSERT(a_one_side_busy, !(s_ready && m_valid), "input and result sides open together")
    `KAT_ASSERT(a_full_zeroed, !(m_valid && m_table_full) || (!m_hit && m_entry_index == '0 && m_wins_now == '0 && m_visits_now == '0), "full result not zeroed")
    `KAT_ASSERT_NEXT(a_scan_start, s_valid && s_ready, state_reg == ST_SCAN && idx_reg == '0, "scan does not start at entry zero")
    `KAT_ASSERT(a_fill_bound, fill_reg <= FILL_W'(TABLE_DEPTH), "fill count beyond table depth")

endmodule

>>> hw/rtl/kat_store.sv
// Entry store: key and counter memory, one write port and one registered read port.
module kat_store (
    input  logic                    aclk,
    input  kat_pkg::wr_req_t        wr,
    input  logic                    rd_en,
    input  logic [kat_pkg::IDX_W-1:0] rd_addr,
    output kat_pkg::entry_t         rd_data
);
    import kat_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
